// ===== sv/gbn_pkg.sv =====
// Shared types and constants for the go-back-n sender window.
// No dependencies; imported by every module of the block.
package gbn_pkg;

  // Event codes carried on the input tuser
  typedef enum logic [1:0] {
    FN_GEN  = 2'd0,
    FN_SEND = 2'd1,
    FN_ACK  = 2'd2,
    FN_TICK = 2'd3
  } fn_e;

  // Result kinds carried on the output tuser
  typedef enum logic [2:0] {
    EV_IDLE    = 3'd0,
    EV_QUEUED  = 3'd1,
    EV_DROPPED = 3'd2,
    EV_SENT    = 3'd3,
    EV_RETIRED = 3'd4,
    EV_REWOUND = 3'd5,
    EV_TERM    = 3'd6
  } evt_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEND_MOD,
    ST_ACK_CHK,
    ST_DIV_WAIT,
    ST_TICK_CHK,
    ST_DONE
  } state_e;

  // Configuration register indexes
  localparam logic [2:0] CFG_WINDOW  = 3'd0;
  localparam logic [2:0] CFG_BUFFER  = 3'd1;
  localparam logic [2:0] CFG_SEQBITS = 3'd2;
  localparam logic [2:0] CFG_GOAL    = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT = 3'd4;

  localparam int unsigned ACK_THRESHOLD = 10;
  localparam int unsigned RTT_W         = 48;
  localparam int unsigned DIV_NUM_W     = RTT_W + 1;
  localparam int unsigned DIV_DEN_W     = 16;

  // Divider handshake
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/gbn_entry_ram.sv =====
// Entry store of the sender queue: one write port, one registered read port.
// Depends on gbn_pkg.
module gbn_entry_ram
  import gbn_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 84
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== sv/gbn_div.sv =====
// Restoring divider, one quotient bit a cycle, for the adaptive timeout.
// Depends on gbn_pkg.
module gbn_div
  import gbn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output div_stat_t            stat_o,
  output logic [DIV_NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DIV_NUM_W + 1);

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   rem_sh;

  // Shift in one dividend bit, subtract when it fits
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    rem_sh = {rem_q, quo_q[DIV_NUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_NUM_W);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = DIV_DEN_W'(rem_sh - {1'b0, den_q});
        quo_d = {quo_q[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_DEN_W-1:0];
        quo_d = {quo_q[DIV_NUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

endmodule

// ===== sv/go_back_n_sender_window_top.sv =====
// Go-back-n sender window: sequencer around the entry store and divider.
// Depends on gbn_pkg, gbn_entry_ram and gbn_div.
//
//  channel | direction | handshake                    | payload
//  input   | in        | s_axis_tvalid/s_axis_tready  | tuser func, tdata ack_seq
//  result  | out       | m_axis_tvalid/m_axis_tready  | tuser event_kind, tdata fields
//  config  | in        | cfg_valid_i/cfg_ready_o      | cfg_addr_i index, cfg_data_i
//
// Each word is decoded in ST_EXEC; generate writes the store there, send reads
// the entry and writes it back with its attempt counted, a tick with ten or more
// acks waits for the divider and a tick with a queued head tests it for timeout,
// and an ack retires entries until the head matches ack_seq or the queue is empty.
// Reset clears all control state; the entry store needs no clearing. A result
// waits in the output register while the next word is taken; the sequencer
// stalls at its end only if the output register is still full.
module go_back_n_sender_window_top
  import gbn_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = 1024,
  parameter int unsigned MAX_ATTEMPTS = 10,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,  // ack_seq
  input  logic [1:0]   s_axis_tuser,  // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tx_seq, tx_attempt, retired_count, queue_count, current_timeout,
  // acked_total, transmissions_total, stopped, finished, zero pad
  output logic [127:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,  // event_kind
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_addr_i,
  input  logic [15:0]  cfg_data_i
);

  localparam int unsigned AW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW   = TIME_BITS;
  localparam int unsigned EW   = 16 + 4 + 2 * TW;
  localparam int unsigned CMPW = (TW > 32) ? TW : 32;

  // Configuration registers
  logic [10:0] win_q, win_d, buf_q, buf_d;
  logic [4:0]  sbits_q, sbits_d;
  logic [15:0] goal_q, goal_d, itmo_q, itmo_d;

  // Window state
  state_e        state_q, state_d;
  logic [1:0]    func_q, func_d;
  logic [15:0]   ack_q, ack_d;
  evt_e          kind_q, kind_d;
  logic [15:0]   txs_q, txs_d;
  logic [3:0]    txa_q, txa_d;
  logic [CW-1:0] ret_q, ret_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d, offset_q, offset_d;
  logic [15:0]   nseq_q, nseq_d;
  logic [TW-1:0] tick_q, tick_d;
  logic [RTT_W-1:0] rtt_q, rtt_d;
  logic [15:0]   acked_q, acked_d;
  logic [31:0]   ttot_q, ttot_d, tmo_q, tmo_d;
  logic          halt_q, halt_d;

  // Result register
  logic          ov_q, ov_d;
  logic [2:0]    o_kind_q, o_kind_d;
  logic [127:0]  o_data_q, o_data_d;

  // Store and divider
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;
  logic          div_start;
  div_stat_t     div_stat;
  logic [DIV_NUM_W-1:0] div_quot;

  // Decoded conditions
  logic          finished, blocked, full, can_send, ack_ge;
  logic          out_free, ack_stop, cfg_we;
  logic [CW-1:0] win_lim;
  logic [15:0]   rd_seq;
  logic [3:0]    rd_att, new_att;
  logic [TW-1:0] rd_last, rd_first, el_time, rtt_one;
  logic [16:0]   seq_max;
  logic [4:0]    sbits_c;
  logic [RTT_W:0] rtt_sum;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(head) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return AW'(sum);
  endfunction

  gbn_entry_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .DW    (EW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  gbn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({rtt_q, 1'b0}),
    .den_i   (acked_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  // Split the entry read back into its fields
  assign rd_seq   = mem_rdata[15:0];
  assign rd_att   = mem_rdata[19:16];
  assign rd_last  = mem_rdata[20 +: TW];
  assign rd_first = mem_rdata[20 + TW +: TW];
  assign new_att  = rd_att + 4'd1;
  assign el_time  = (rd_att != 4'd0) ? TW'(tick_q - rd_last) : '0;
  assign rtt_one  = (rd_att != 4'd0) ? TW'(tick_q - rd_first) : '0;
  assign rtt_sum  = (RTT_W+1)'(rtt_q) + (RTT_W+1)'(rtt_one);

  // Decode the current event
  assign finished = (acked_q >= goal_q);
  assign blocked  = halt_q || finished;
  assign full     = (32'(count_q) >= 32'(buf_q)) || (32'(count_q) >= 32'(QUEUE_DEPTH));
  assign win_lim  = (32'(count_q) < 32'(win_q)) ? count_q : CW'(win_q);
  assign can_send = (count_q != '0) && (offset_q < win_lim);
  assign ack_ge   = (32'(acked_q) >= 32'(ACK_THRESHOLD));
  assign ack_stop = (count_q == '0) || (rd_seq == ack_q);
  assign out_free = !ov_q || m_axis_tready;
  assign cfg_we   = cfg_valid_i && cfg_ready_o;
  assign sbits_c  = (sbits_q == 5'd0) ? 5'd1 : ((sbits_q > 5'd16) ? 5'd16 : sbits_q);
  assign seq_max  = (17'd1 << sbits_c) - 17'd1;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (blocked) state_d = ST_DONE;
        else if (fn_e'(func_q) == FN_SEND && can_send) state_d = ST_SEND_MOD;
        else if (fn_e'(func_q) == FN_ACK && count_q != '0) state_d = ST_ACK_CHK;
        else if (fn_e'(func_q) == FN_TICK && ack_ge) state_d = ST_DIV_WAIT;
        else if (fn_e'(func_q) == FN_TICK && count_q != '0) state_d = ST_TICK_CHK;
        else state_d = ST_DONE;
      end
      ST_SEND_MOD: state_d = ST_DONE;
      ST_ACK_CHK: begin
        if (ack_stop) state_d = ST_DONE;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) state_d = (count_q != '0) ? ST_TICK_CHK : ST_DONE;
      end
      ST_TICK_CHK: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and store access
  always_comb begin
    func_d   = func_q;
    ack_d    = ack_q;
    kind_d   = kind_q;
    txs_d    = txs_q;
    txa_d    = txa_q;
    ret_d    = ret_q;
    addr_d   = addr_q;
    head_d   = head_q;
    count_d  = count_q;
    offset_d = offset_q;
    nseq_d   = nseq_q;
    tick_d   = tick_q;
    rtt_d    = rtt_q;
    acked_d  = acked_q;
    ttot_d   = ttot_q;
    tmo_d    = tmo_q;
    halt_d   = halt_q;
    ov_d     = ov_q && !m_axis_tready;
    o_kind_d = o_kind_q;
    o_data_d = o_data_q;
    win_d    = win_q;
    buf_d    = buf_q;
    sbits_d  = sbits_q;
    goal_d   = goal_q;
    itmo_d   = itmo_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = head_q;
    div_start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        // Latch the incoming word
        if (s_axis_tvalid) begin
          func_d = s_axis_tuser;
          ack_d  = s_axis_tdata;
        end
      end
      ST_EXEC: begin
        kind_d = EV_IDLE;
        txs_d  = '0;
        txa_d  = '0;
        ret_d  = '0;
        priority if (blocked) begin
          kind_d = EV_TERM;
        end else if (fn_e'(func_q) == FN_GEN) begin
          // Queue a new number or drop it
          if (full) begin
            kind_d = EV_DROPPED;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = slot_of(head_q, count_q);
            mem_wdata = {{(2 * TW){1'b0}}, 4'd0, nseq_q};
            txs_d     = nseq_q;
            count_d   = count_q + 1'b1;
            nseq_d    = ({1'b0, nseq_q} >= seq_max) ? 16'd0 : nseq_q + 16'd1;
            kind_d    = EV_QUEUED;
          end
        end else if (fn_e'(func_q) == FN_SEND) begin
          if (can_send) begin
            mem_re    = 1'b1;
            mem_raddr = slot_of(head_q, offset_q);
            addr_d    = mem_raddr;
          end
        end else if (fn_e'(func_q) == FN_ACK) begin
          mem_re = (count_q != '0);
        end else begin
          // Advance time and refresh the timeout
          tick_d = tick_q + 1'b1;
          if (ack_ge) begin
            div_start = 1'b1;
          end else begin
            tmo_d  = 32'(itmo_q);
            mem_re = (count_q != '0);
          end
        end
      end
      ST_SEND_MOD: begin
        // Count the attempt and write the entry back
        mem_we    = 1'b1;
        mem_wdata = {(rd_att == 4'd0) ? tick_q : rd_first, tick_q, new_att, rd_seq};
        ttot_d    = ttot_q + 32'd1;
        txs_d     = rd_seq;
        txa_d     = new_att;
        if (32'(new_att) >= 32'(MAX_ATTEMPTS)) begin
          halt_d = 1'b1;
          kind_d = EV_TERM;
        end else begin
          offset_d = offset_q + 1'b1;
          kind_d   = EV_SENT;
        end
      end
      ST_ACK_CHK: begin
        // Retire the head and read the next one
        if (ack_stop) begin
          kind_d = EV_RETIRED;
        end else begin
          rtt_d     = rtt_sum[RTT_W] ? {RTT_W{1'b1}} : rtt_sum[RTT_W-1:0];
          acked_d   = (acked_q == 16'hFFFF) ? acked_q : acked_q + 16'd1;
          head_d    = slot_of(head_q, CW'(1));
          count_d   = count_q - 1'b1;
          offset_d  = (offset_q != '0) ? offset_q - 1'b1 : offset_q;
          ret_d     = ret_q + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = head_d;
        end
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          tmo_d  = (div_quot[DIV_NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
          mem_re = (count_q != '0);
        end
      end
      ST_TICK_CHK: begin
        // Rewind when the head has timed out
        if (CMPW'(el_time) >= CMPW'(tmo_q)) begin
          offset_d = '0;
          kind_d   = EV_REWOUND;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ov_d     = 1'b1;
          o_kind_d = kind_q;
          o_data_d = {4'd0, finished, halt_q, ttot_q, acked_q, tmo_q,
                      11'(count_q), 11'(ret_q), txa_q, txs_q};
        end
      end
      default: ;
    endcase

    // Configuration writes must arrive only while idle; the block does not enforce this
    if (cfg_we) begin
      unique case (cfg_addr_i)
        CFG_WINDOW:  win_d   = cfg_data_i[10:0];
        CFG_BUFFER:  buf_d   = cfg_data_i[10:0];
        CFG_SEQBITS: sbits_d = cfg_data_i[4:0];
        CFG_GOAL:    goal_d  = cfg_data_i;
        CFG_TIMEOUT: begin
          itmo_d = cfg_data_i;
          if (!ack_ge) tmo_d = 32'(cfg_data_i);
        end
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      offset_q <= '0;
      nseq_q   <= '0;
      tick_q   <= '0;
      rtt_q    <= '0;
      acked_q  <= '0;
      ttot_q   <= '0;
      tmo_q    <= 32'd300;
      halt_q   <= 1'b0;
      ov_q     <= 1'b0;
      win_q    <= 11'd4;
      buf_q    <= 11'd1000;
      sbits_q  <= 5'd10;
      goal_q   <= 16'd20;
      itmo_q   <= 16'd300;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      offset_q <= offset_d;
      nseq_q   <= nseq_d;
      tick_q   <= tick_d;
      rtt_q    <= rtt_d;
      acked_q  <= acked_d;
      ttot_q   <= ttot_d;
      tmo_q    <= tmo_d;
      halt_q   <= halt_d;
      ov_q     <= ov_d;
      win_q    <= win_d;
      buf_q    <= buf_d;
      sbits_q  <= sbits_d;
      goal_q   <= goal_d;
      itmo_q   <= itmo_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    ack_q    <= ack_d;
    kind_q   <= kind_d;
    txs_q    <= txs_d;
    txa_q    <= txa_d;
    ret_q    <= ret_d;
    addr_q   <= addr_d;
    o_kind_q <= o_kind_d;
    o_data_q <= o_data_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tdata  = o_data_q;

  // Queue occupancy stays within the store
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // Send offset never passes the queued entries
  a_offset_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q <= count_q)
    else $error("send offset beyond entry count");

  // Divider runs only inside a tick
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == ST_DIV_WAIT)
    else $error("divider busy outside tick handling");

  // A halt is never undone
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt cleared");

endmodule
